// ===== rtl/wgm_pkg.sv =====
package wgm_pkg;

  localparam int unsigned PATTERN_MAX = 64;
  localparam int unsigned LEN_W       = $clog2(PATTERN_MAX + 1);

  localparam logic [7:0] STAR_BYTE  = 8'h2A;
  localparam logic [7:0] QMARK_BYTE = 8'h3F;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  typedef enum logic [1:0] {
    FUNC_CLEAR  = 2'd0,
    FUNC_APPEND = 2'd1,
    FUNC_SUBJ   = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_e;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic       step;     // subject byte accepted, advance the position set
    logic       start;    // this byte opens a new subject string
    logic [7:0] sub;      // folded subject byte
    logic [7:0] wr_byte;  // raw pattern byte being appended
    logic       lead;     // every stored pattern byte so far is a star
  } cell_ctrl_t;

  function automatic logic [7:0] fold_case(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= UPPER_A && b <= UPPER_Z) begin
      r = b | CASE_BIT;
    end
    return r;
  endfunction

endpackage

// ===== rtl/wildcard_glob_match.sv =====
// wildcard (glob) matcher, case-insensitive for ascii letters
// input stream: each beat carries a command in s_axis_tuser_i: clear pattern,
// append pattern byte, subject byte, or empty-subject query. the byte rides in
// s_axis_tdata_i, and s_axis_tlast_i marks the final byte of a subject string.
// output stream: one beat per finished subject (subject byte with tlast) and
// per empty-subject query; tdata bit 0 is the match, tuser flags an overflowed
// pattern (match then forced low). other commands give no output beat.
// the pattern lives in a row of cells, one per pattern position; each cell
// keeps its pattern byte and its bit of the nfa state. a subject byte updates
// every cell in the cycle it is accepted, with star closure rippling cell to
// cell like a carry chain, so one beat is taken per cycle while s_axis_tready_o is high.
// the result beat is registered and appears in the cycle after the closing input beat.
// the output register decouples the two sides: a new beat is taken whenever
// the output register is empty or being drained in the same cycle; if the
// receiver stalls with a result pending, s_axis_tready_o drops until it drains.
// reset: empty pattern, no overflow, no pending output, next byte opens a
// new subject string. pattern bytes themselves are not cleared.
module wildcard_glob_match (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] char_byte
  input  logic [1:0] s_axis_tuser_i,   // [1:0] func
  input  logic       s_axis_tlast_i,   // last byte of a subject
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [0] matched, [7:1] zero
  output logic       m_axis_tuser_o    // [0] pattern_overflow
);
  import wgm_pkg::*;

  logic [LEN_W-1:0] len_q;
  logic             ovf_q;
  logic             all_star_q;  // pattern is empty or only stars
  logic             start_q;     // next subject byte opens a string
  logic             m_valid_q;
  logic             matched_q;
  logic             ovf_out_q;

  logic             accept;
  func_e            func;
  cell_ctrl_t       ctrl;
  logic             full;

  logic [PATTERN_MAX:0]   carry_w;
  logic [PATTERN_MAX:0]   fwd_w;
  logic [PATTERN_MAX-1:0] hit_w;
  logic                   tail_hit;
  logic                   subj_hit;

  assign func   = func_e'(s_axis_tuser_i);
  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign full   = (len_q == LEN_W'(PATTERN_MAX));

  assign s_axis_tready_o = ~m_valid_q | m_axis_tready_i;

  assign ctrl.step    = accept & (func == FUNC_SUBJ);
  assign ctrl.start   = start_q;
  assign ctrl.sub     = fold_case(s_axis_tdata_i);
  assign ctrl.wr_byte = s_axis_tdata_i;
  assign ctrl.lead    = all_star_q;

  // no transition enters the chain from the left of position zero
  assign carry_w[0] = 1'b0;
  assign fwd_w[0]   = 1'b0;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    wgm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .wr_en_i (accept & (func == FUNC_APPEND) & (len_q == LEN_W'(g))),
      .en_i    (len_q > LEN_W'(g)),
      .tail_i  (len_q == LEN_W'(g)),
      .carry_i (carry_w[g]),
      .fwd_i   (fwd_w[g]),
      .carry_o (carry_w[g+1]),
      .fwd_o   (fwd_w[g+1]),
      .hit_o   (hit_w[g])
    );
  end

  // end position of a full store sits past the last cell
  assign tail_hit = full & (carry_w[PATTERN_MAX] | fwd_w[PATTERN_MAX]);
  assign subj_hit = (|hit_w) | tail_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= '0;
      ovf_q      <= 1'b0;
      all_star_q <= 1'b1;
      start_q    <= 1'b1;
      m_valid_q  <= 1'b0;
      matched_q  <= 1'b0;
      ovf_out_q  <= 1'b0;
    end else begin
      if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      if (accept) begin
        case (func)
          FUNC_CLEAR: begin
            len_q      <= '0;
            ovf_q      <= 1'b0;
            all_star_q <= 1'b1;
            start_q    <= 1'b1;
          end
          FUNC_APPEND: begin
            if (full) begin
              ovf_q <= 1'b1;
            end else begin
              len_q      <= len_q + LEN_W'(1);
              all_star_q <= all_star_q & (s_axis_tdata_i == STAR_BYTE);
            end
            start_q <= 1'b1;
          end
          FUNC_SUBJ: begin
            start_q <= s_axis_tlast_i;
            if (s_axis_tlast_i) begin
              m_valid_q <= 1'b1;
              matched_q <= ~ovf_q & subj_hit;
              ovf_out_q <= ovf_q;
            end
          end
          FUNC_QUERY: begin
            // empty subject: matches an empty or all-star pattern
            start_q   <= 1'b1;
            m_valid_q <= 1'b1;
            matched_q <= ~ovf_q & all_star_q;
            ovf_out_q <= ovf_q;
          end
          default: begin
            start_q <= 1'b1;
          end
        endcase
      end
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'd0, matched_q};
  assign m_axis_tuser_o  = ovf_out_q;

endmodule

// ===== rtl/wgm_cell.sv =====
module wgm_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  wgm_pkg::cell_ctrl_t ctrl_i,
  input  logic                wr_en_i,   // append lands in this cell
  input  logic                en_i,      // position lies inside the pattern
  input  logic                tail_i,    // position equals the pattern length
  input  logic                carry_i,   // star closure from the left
  input  logic                fwd_i,     // consuming move from the left
  output logic                carry_o,
  output logic                fwd_o,
  output logic                hit_o
);
  import wgm_pkg::*;

  logic [7:0] pat_q;
  logic       star_q;
  logic       qmark_q;
  logic       lead_q;
  logic       act_q;
  logic       act_d;
  logic       cur;
  logic       self_loop;

  // position set seen by this byte
  assign cur       = ctrl_i.start ? lead_q : act_q;
  assign self_loop = en_i & cur & star_q;
  assign fwd_o     = en_i & cur & ~star_q & (qmark_q | (pat_q == ctrl_i.sub));
  assign act_d     = self_loop | fwd_i | carry_i;
  assign carry_o   = en_i & star_q & act_d;
  assign hit_o     = tail_i & act_d;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pat_q   <= fold_case(ctrl_i.wr_byte);
      star_q  <= (ctrl_i.wr_byte == STAR_BYTE);
      qmark_q <= (ctrl_i.wr_byte == QMARK_BYTE);
      lead_q  <= ctrl_i.lead;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
    end else if (ctrl_i.step) begin
      act_q <= act_d;
    end
  end

endmodule
